FILE: rtl/ttc_pkg.sv
// shared types and constants for the utf-8 to cesu-8 transcoder
// job word passed from the front classifier to the byte serializer
// no dependencies
package ttc_pkg;

  localparam int CAP_BITS   = 24;
  localparam int ACC_BITS   = 21;
  localparam int JOB_BYTES  = 6;
  localparam int CNT_BITS   = 3;

  localparam logic [7:0] BYTE_NUL   = 8'h00;
  localparam logic [7:0] BYTE_ED    = 8'hED;
  localparam logic [7:0] BYTE_EF    = 8'hEF;
  localparam logic [7:0] BYTE_BF    = 8'hBF;
  localparam logic [7:0] BYTE_BD    = 8'hBD;
  localparam logic [7:0] BYTE_A0    = 8'hA0;
  localparam logic [7:0] BYTE_B0    = 8'hB0;
  localparam logic [7:0] BYTE_C0    = 8'hC0;
  localparam logic [7:0] BYTE_E0    = 8'hE0;
  localparam logic [7:0] BYTE_CONT  = 8'h80;
  localparam logic [5:0] LOW6_MASK  = 6'h3F;

  localparam logic [CNT_BITS-1:0] LEN_ONE  = 3'd1;
  localparam logic [CNT_BITS-1:0] LEN_TWO  = 3'd2;
  localparam logic [CNT_BITS-1:0] LEN_REP  = 3'd3;
  localparam logic [CNT_BITS-1:0] LEN_PAIR = 3'd6;

  typedef struct packed {
    logic [JOB_BYTES-1:0][7:0] bytes;
    logic [CNT_BITS-1:0]       count;
    logic [CAP_BITS-1:0]       total;
  } job_t;

  typedef struct packed {
    logic [JOB_BYTES-1:0][7:0] bytes;
    logic [CNT_BITS-1:0]       len;
  } units_t;

  function automatic units_t encode_code(input logic [ACC_BITS-1:0] cp);
    units_t     u;
    logic [4:0] plane;
    u = '0;
    plane = cp[20:16] - 5'd1;
    if (cp[20:11] == '0) begin
      u.bytes[0] = BYTE_C0 | {3'b000, cp[10:6]};
      u.bytes[1] = BYTE_CONT | {2'b00, cp[5:0]};
      u.len = LEN_TWO;
    end else if (cp[20:16] == '0) begin
      u.bytes[0] = BYTE_E0 | {4'b0000, cp[15:12]};
      u.bytes[1] = BYTE_CONT | {2'b00, cp[11:6]};
      u.bytes[2] = BYTE_CONT | {2'b00, cp[5:0]};
      u.len = LEN_REP;
    end else begin
      u.bytes[0] = BYTE_ED;
      u.bytes[1] = BYTE_A0 | {4'b0000, plane[3:0]};
      u.bytes[2] = BYTE_CONT | {2'b00, cp[15:10]};
      u.bytes[3] = BYTE_ED;
      u.bytes[4] = BYTE_B0 | {4'b0000, cp[9:6]};
      u.bytes[5] = BYTE_CONT | {2'b00, cp[5:0] & LOW6_MASK};
      u.len = LEN_PAIR;
    end
    return u;
  endfunction

endpackage

FILE: rtl/ttc_front.sv
// front end: accepts utf-8 bytes, tracks sequence state and output count
// builds one job word per byte that produces output; uses ttc_pkg
module ttc_front import ttc_pkg::*; #(
  parameter int LENGTH_BITS = 24
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          in_byte,
  input  logic [CAP_BITS-1:0] capacity,
  input  logic                q_full,
  output logic                push,
  output job_t                job
);

  localparam int SW = ((LENGTH_BITS > CAP_BITS) ? LENGTH_BITS : CAP_BITS) + 1;

  logic [1:0]             pending, pending_next;
  logic [ACC_BITS-1:0]    acc, acc_next;
  logic [LENGTH_BITS-1:0] written, written_next;

  logic                   accept;
  logic [SW-1:0]          cap_ext, w_ext, sum1, sum2, sum3, sum4, sum6;
  logic                   fit1, fit2, fit3, fit4, fit6;
  logic [ACC_BITS-1:0]    acc_cat;
  logic [LENGTH_BITS-1:0] tl_len;
  logic [SW-1:0]          tl_ext;
  logic                   is_cont;
  units_t                 enc;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign cap_ext  = SW'(capacity);
  assign w_ext    = SW'(written);
  assign sum1     = w_ext + SW'(1);
  assign sum2     = w_ext + SW'(2);
  assign sum3     = w_ext + SW'(3);
  assign sum4     = w_ext + SW'(4);
  assign sum6     = w_ext + SW'(6);
  assign fit1     = sum1 < cap_ext;
  assign fit2     = sum2 < cap_ext;
  assign fit3     = sum3 < cap_ext;
  assign fit4     = sum4 < cap_ext;
  assign fit6     = sum6 < cap_ext;
  assign acc_cat  = {acc[ACC_BITS-7:0], in_byte[5:0]};
  assign tl_len   = sum1[LENGTH_BITS-1:0];
  assign tl_ext   = SW'(tl_len);
  assign is_cont  = (in_byte[7:6] == 2'b10);
  assign enc      = encode_code(acc_cat);

  always_comb begin
    logic rep_a;
    rep_a        = 1'b0;
    pending_next = pending;
    acc_next     = acc;
    written_next = written;
    job          = '0;
    if (in_byte == BYTE_NUL) begin
      job.bytes[0] = BYTE_NUL;
      job.count    = LEN_ONE;
      job.total    = tl_ext[CAP_BITS-1:0];
      pending_next = '0;
      acc_next     = '0;
      written_next = '0;
    end else if (fit1) begin
      if (pending != 2'd0 && is_cont) begin
        acc_next     = acc_cat;
        pending_next = pending - 2'd1;
        if (pending == 2'd1) begin
          if (enc.len == LEN_TWO && fit2) begin
            job.bytes    = enc.bytes;
            job.count    = enc.len;
            written_next = sum2[LENGTH_BITS-1:0];
          end else if (enc.len == LEN_REP && fit3) begin
            job.bytes    = enc.bytes;
            job.count    = enc.len;
            written_next = sum3[LENGTH_BITS-1:0];
          end else if (enc.len == LEN_PAIR && fit6) begin
            job.bytes    = enc.bytes;
            job.count    = enc.len;
            written_next = sum6[LENGTH_BITS-1:0];
          end
        end
      end else begin
        // broken sequence gives a replacement before the byte is reclassified
        pending_next = '0;
        if (pending != 2'd0 && fit3) begin
          rep_a        = 1'b1;
          job.bytes[0] = BYTE_EF;
          job.bytes[1] = BYTE_BF;
          job.bytes[2] = BYTE_BD;
          job.count    = LEN_REP;
          written_next = sum3[LENGTH_BITS-1:0];
        end
        if (!in_byte[7]) begin
          if (rep_a && fit4) begin
            job.bytes[3] = in_byte;
            job.count    = LEN_REP + LEN_ONE;
            written_next = sum4[LENGTH_BITS-1:0];
          end else if (!rep_a) begin
            job.bytes[0] = in_byte;
            job.count    = LEN_ONE;
            written_next = sum1[LENGTH_BITS-1:0];
          end
        end else if (in_byte[7:5] == 3'b110) begin
          acc_next     = ACC_BITS'(in_byte[4:0]);
          pending_next = 2'd1;
        end else if (in_byte[7:4] == 4'b1110) begin
          acc_next     = ACC_BITS'(in_byte[3:0]);
          pending_next = 2'd2;
        end else if (in_byte[7:3] == 5'b11110) begin
          acc_next     = ACC_BITS'(in_byte[2:0]);
          pending_next = 2'd3;
        end else if (rep_a) begin
          if (fit6) begin
            job.bytes[3] = BYTE_EF;
            job.bytes[4] = BYTE_BF;
            job.bytes[5] = BYTE_BD;
            job.count    = LEN_PAIR;
            written_next = sum6[LENGTH_BITS-1:0];
          end
        end else if (fit3) begin
          job.bytes[0] = BYTE_EF;
          job.bytes[1] = BYTE_BF;
          job.bytes[2] = BYTE_BD;
          job.count    = LEN_REP;
          written_next = sum3[LENGTH_BITS-1:0];
        end
      end
    end
  end

  assign push = accept && (job.count != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
      acc     <= '0;
      written <= '0;
    end else if (accept) begin
      pending <= pending_next;
      acc     <= acc_next;
      written <= written_next;
    end
  end

endmodule

FILE: rtl/ttc_queue.sv
// two-entry job queue between the front end and the byte serializer
// uses ttc_pkg for the job word
module ttc_queue import ttc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t job_in,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output job_t head
);

  job_t       entries [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] fill;

  assign full       = (fill == 2'd2);
  assign head_valid = (fill != 2'd0);
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= job_in;
  end

endmodule

FILE: rtl/ttc_back.sv
// back end: walks the head job one byte a cycle, unless the output stalls, into the output register
// uses ttc_pkg for the job word
module ttc_back import ttc_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                head_valid,
  input  job_t                head,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_byte,
  output logic                last_of_run,
  output logic [CAP_BITS-1:0] total_length
);

  logic [CNT_BITS-1:0] idx, idx_next;
  logic                load;
  logic                at_last;

  assign load    = head_valid && (!out_valid || !out_stall);
  assign at_last = (idx == head.count - LEN_ONE);
  assign pop     = load && at_last;

  always_comb begin
    idx_next = idx;
    if (load) begin
      idx_next = at_last ? '0 : idx + LEN_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      idx <= idx_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte     <= head.bytes[idx];
      last_of_run  <= at_last;
      total_length <= head.total;
    end
  end

endmodule

FILE: rtl/utf8_to_cesu8_transcoder_unit.sv
// top level of the utf-8 to cesu-8 transcoder
// instantiates ttc_front, ttc_queue and ttc_back; uses ttc_pkg
//
// Takes one UTF-8 byte per cycle unless stalled and emits CESU-8 bytes one
// per cycle unless out_stall holds them; a zero byte ends the string and
// yields a terminator carrying total_length. The input takes a byte every
// cycle while the two-entry job queue has room; the output serializer drains
// one byte per cycle unless stalled, so an input byte that expands to more
// than one byte holds its queue slot until its last byte is taken, and a
// long run of multi-byte output throttles the input to the output rate.
// out_capacity is written through the cfg port, which is always ready.
module utf8_to_cesu8_transcoder_unit import ttc_pkg::*; #(
  parameter int LENGTH_BITS = 24
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CAP_BITS-1:0] out_capacity,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          in_byte,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_byte,
  output logic                last_of_run,
  output logic [CAP_BITS-1:0] total_length
);

  logic [CAP_BITS-1:0] capacity;
  logic                q_full, push, pop, head_valid;
  job_t                job, head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= '1;
    end else if (cfg_valid && cfg_ready) begin
      capacity <= out_capacity;
    end
  end

  ttc_front #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_byte  (in_byte),
    .capacity (capacity),
    .q_full   (q_full),
    .push     (push),
    .job      (job)
  );

  ttc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .job_in     (job),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  ttc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .last_of_run  (last_of_run),
    .total_length (total_length)
  );

endmodule

FILE: test/utf8_to_cesu8_transcoder_unit_tb.sv
// testbench for utf8_to_cesu8_transcoder_unit: directed and random utf-8 text,
// with the cesu-8 bytes predicted in place and checked word by word
// depends on ttc_pkg and the rtl of the transcoder
module utf8_to_cesu8_transcoder_unit_tb import ttc_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LENGTH_BITS = 24;
  localparam int IDLE_LIMIT  = 3000;
  localparam logic [CAP_BITS-1:0] CAP_MAX = 24'hFFFFFF;

  typedef struct packed {
    logic [7:0]          b;
    logic                last;
    logic [CAP_BITS-1:0] total;
  } cesu_word_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CAP_BITS-1:0] out_capacity = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [7:0]          in_byte = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [7:0]          out_byte;
  logic                last_of_run;
  logic [CAP_BITS-1:0] total_length;

  cesu_word_t  pending_words[$];
  logic [7:0]  step_bytes[$];

  logic [CAP_BITS-1:0]    capacity_shadow = CAP_MAX;
  logic [1:0]             cont_left = '0;
  logic [ACC_BITS-1:0]    code_point = '0;
  logic [LENGTH_BITS-1:0] written_len = '0;

  int sender_gap_pct = 0;
  int receiver_stall_pct = 0;
  int hold_request = 0;
  int hold_left = 0;
  int fail_count = 0;
  int idle_cycles = 0;

  utf8_to_cesu8_transcoder_unit #(.LENGTH_BITS(LENGTH_BITS)) dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .out_capacity (out_capacity),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_byte      (in_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .last_of_run  (last_of_run),
    .total_length (total_length)
  );

  always #4 clk = ~clk;

  // cesu-8 prediction
  function automatic void emit_unit(input logic [7:0] u0, u1, u2, u3, u4, u5, input int n);
    logic [7:0] u[6];
    u = '{u0, u1, u2, u3, u4, u5};
    if (longint'(written_len) + n >= longint'(capacity_shadow)) return;
    for (int k = 0; k < n; k++) step_bytes.push_back(u[k]);
    written_len = written_len + LENGTH_BITS'(n);
  endfunction

  function automatic void emit_replacement();
    emit_unit(BYTE_EF, BYTE_BF, BYTE_BD, 8'h00, 8'h00, 8'h00, 3);
  endfunction

  function automatic void emit_code_point(input logic [ACC_BITS-1:0] cp);
    logic [4:0] plane;
    plane = cp[20:16] - 5'd1;
    if (cp <= 21'h7FF)
      emit_unit(8'hC0 + cp[10:6], 8'h80 + cp[5:0], 8'h00, 8'h00, 8'h00, 8'h00, 2);
    else if (cp <= 21'hFFFF)
      emit_unit(8'hE0 + cp[15:12], 8'h80 + cp[11:6], 8'h80 + cp[5:0],
                8'h00, 8'h00, 8'h00, 3);
    else
      emit_unit(BYTE_ED, BYTE_A0 + plane[3:0], 8'h80 + cp[15:10],
                BYTE_ED, BYTE_B0 + cp[9:6], 8'h80 + cp[5:0], 6);
  endfunction

  function automatic void transcode_byte(input logic [7:0] b);
    cesu_word_t w;
    logic       done;
    done = 1'b0;
    step_bytes.delete();
    if (b == 8'h00) begin
      w.b = 8'h00;
      w.last = 1'b1;
      w.total = CAP_BITS'(written_len + 1'b1);
      pending_words.push_back(w);
      cont_left = '0;
      code_point = '0;
      written_len = '0;
      return;
    end
    if (longint'(written_len) + 1 >= longint'(capacity_shadow)) return;
    if (cont_left != 0) begin
      if (b[7:6] == 2'b10) begin
        code_point = {code_point[14:0], b[5:0]};
        cont_left = cont_left - 1'b1;
        if (cont_left == 0) emit_code_point(code_point);
        done = 1'b1;
      end else begin
        emit_replacement();
        cont_left = '0;
      end
    end
    if (!done) begin
      if (!b[7]) begin
        emit_unit(b, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1);
      end else if (b[7:5] == 3'b110) begin
        code_point = ACC_BITS'(b[4:0]);
        cont_left = 2'd1;
      end else if (b[7:4] == 4'b1110) begin
        code_point = ACC_BITS'(b[3:0]);
        cont_left = 2'd2;
      end else if (b[7:3] == 5'b11110) begin
        code_point = ACC_BITS'(b[2:0]);
        cont_left = 2'd3;
      end else begin
        emit_replacement();
        cont_left = '0;
      end
    end
    for (int k = 0; k < step_bytes.size(); k++) begin
      w.b = step_bytes[k];
      w.last = (k == step_bytes.size() - 1);
      w.total = '0;
      pending_words.push_back(w);
    end
  endfunction

  // receiver: random stalls plus long hold-offs on request
  always @(posedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
    end
  end

  // output word check
  always @(posedge clk) begin
    cesu_word_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_words.size() == 0) begin
        if (fail_count < 10)
          $display("unexpected word: byte %h last %b total %0d",
                   out_byte, last_of_run, total_length);
        fail_count++;
      end else begin
        want = pending_words.pop_front();
        if (out_byte !== want.b || last_of_run !== want.last || total_length !== want.total) begin
          if (fail_count < 10)
            $display("mismatch: expected byte %h last %b total %0d, got byte %h last %b total %0d",
                     want.b, want.last, want.total, out_byte, last_of_run, total_length);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles = idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
      $display("utf8_to_cesu8_transcoder_unit regression: fail");
      $finish;
    end
  end

  task automatic send_utf8(input logic [7:0] b);
    int gaps;
    gaps = 0;
    while (gaps < 20 && $urandom_range(0, 99) < sender_gap_pct) gaps++;
    if (gaps > 0) begin
      in_valid <= 1'b0;
      repeat (gaps) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    transcode_byte(b);
  endtask

  task automatic wait_until_quiet();
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [CAP_BITS-1:0] v);
    cfg_valid <= 1'b1;
    out_capacity <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    capacity_shadow = v;
    cfg_valid <= 1'b0;
  endtask

  task automatic send_sequence(input logic [7:0] lead, input int n_cont);
    send_utf8(lead);
    for (int k = 0; k < n_cont; k++) send_utf8(8'h80 | 8'($urandom_range(0, 63)));
  endtask

  task automatic test_directed_forms();
    logic [7:0] seq[$];
    seq = '{8'h01, 8'h7F, 8'hC2, 8'hA9, 8'hE2, 8'h82, 8'hAC,
            8'hF0, 8'h9F, 8'h98, 8'h80, 8'hF4, 8'h8F, 8'hBF, 8'hBF,
            8'h80, 8'hBF, 8'hF8, 8'hFF, 8'hE2, 8'h41, 8'hF0, 8'h9F, 8'h00};
    set_capacity(CAP_MAX);
    foreach (seq[k]) send_utf8(seq[k]);
    wait_until_quiet();
  endtask

  task automatic test_capacity_limits();
    logic [7:0] seq[$];
    // smallest buffer: only the terminator fits
    set_capacity(24'd1);
    send_utf8(8'h41);
    send_utf8(8'hC2);
    send_utf8(8'hA9);
    send_utf8(8'h00);
    wait_until_quiet();
    // a unit that does not fit is dropped whole
    set_capacity(24'd5);
    seq = '{8'hE2, 8'h82, 8'hAC, 8'h41, 8'h42, 8'hF0, 8'h00};
    foreach (seq[k]) send_utf8(seq[k]);
    wait_until_quiet();
    // capacity lowered in the middle of a string
    set_capacity(CAP_MAX);
    send_utf8(8'h61);
    send_utf8(8'h62);
    send_utf8(8'h63);
    send_utf8(8'hE2);
    wait_until_quiet();
    set_capacity(24'd3);
    send_utf8(8'h82);
    send_utf8(8'h64);
    send_utf8(8'h00);
    wait_until_quiet();
  endtask

  task automatic test_random_text(input logic [CAP_BITS-1:0] cap, input int n_bytes);
    int start;
    int r;
    start = 0;
    set_capacity(cap);
    while (start < n_bytes) begin
      for (int c = $urandom_range(1, 12); c > 0; c--) begin
        r = $urandom_range(0, 99);
        if (r < 38) begin
          send_utf8(8'($urandom_range(1, 127)));
          start += 1;
        end else if (r < 56) begin
          send_sequence(8'($urandom_range(8'hC0, 8'hDF)), 1);
          start += 2;
        end else if (r < 72) begin
          send_sequence(8'($urandom_range(8'hE0, 8'hEF)), 2);
          start += 3;
        end else if (r < 86) begin
          send_sequence(8'($urandom_range(8'hF0, 8'hF7)), 3);
          start += 4;
        end else if (r < 93) begin
          send_sequence(8'($urandom_range(8'hE0, 8'hF7)), 1);
          start += 2;
        end else begin
          send_utf8(8'($urandom_range(1, 255)));
          start += 1;
        end
      end
      send_utf8(8'h00);
      start += 1;
    end
    wait_until_quiet();
  endtask

  task automatic test_output_backpressure();
    set_capacity(CAP_MAX);
    hold_request = 80;
    for (int k = 0; k < 12; k++) send_sequence(8'($urandom_range(8'hF0, 8'hF4)), 3);
    send_utf8(8'h00);
    wait_until_quiet();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    sender_gap_pct = 34;
    receiver_stall_pct = 48;
    test_directed_forms();
    test_capacity_limits();
    test_random_text(CAP_MAX, 80);
    sender_gap_pct = 48;
    receiver_stall_pct = 34;
    test_random_text(24'($urandom_range(6, 40)), 80);
    test_output_backpressure();
    sender_gap_pct = 0;
    receiver_stall_pct = 0;
    test_random_text(24'($urandom_range(40, 200)), 80);
    repeat (10) @(posedge clk);
    if (fail_count == 0)
      $display("utf8_to_cesu8_transcoder_unit regression: pass");
    else
      $display("utf8_to_cesu8_transcoder_unit regression: fail");
    $finish;
  end

endmodule

FILE: files.f
rtl/ttc_pkg.sv
rtl/ttc_front.sv
rtl/ttc_queue.sv
rtl/ttc_back.sv
rtl/utf8_to_cesu8_transcoder_unit.sv
test/utf8_to_cesu8_transcoder_unit_tb.sv
